FILE: design/tod_pkg.sv
// Shared types and constants of the time-of-day tenths counter.
package tod_pkg;

    localparam int COUNT_W = 20;

    // One day, one hour, one minute and one second in tenths of a second.
    localparam logic [COUNT_W-1:0] DAY_TENTHS    = 20'd864000;
    localparam logic [COUNT_W-1:0] HOUR_TENTHS   = 20'd36000;
    localparam logic [COUNT_W-1:0] MINUTE_TENTHS = 20'd600;
    localparam logic [COUNT_W-1:0] SECOND_TENTHS = 20'd10;

    // Reciprocal multipliers: floor(x / d) == (x * MULT) >> SHIFT for every x below
    // one day, since x * (MULT * d - 2**SHIFT) stays below 2**SHIFT.
    localparam logic [COUNT_W-1:0] DIV10_MULT    = 20'd838861;
    localparam int                 DIV10_SHIFT   = 23;
    localparam logic [COUNT_W-1:0] DIV600_MULT   = 20'd894785;
    localparam int                 DIV600_SHIFT  = 29;
    localparam logic [COUNT_W-1:0] DIV36K_MULT   = 20'd954438;
    localparam int                 DIV36K_SHIFT  = 35;

    // Widths of the quotients: total seconds, total minutes and hours in a day.
    localparam int SECS_W  = 17;
    localparam int MINS_W  = 11;
    localparam int HOURS_W = 5;

    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_ADD   = 3'd1,
        MODE_SUB   = 3'd2,
        MODE_SET   = 3'd3,
        MODE_CLEAR = 3'd4
    } mode_t;

    // New count handed from the update stage to the breakdown stage.
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } tod_count_t;

endpackage

FILE: design/time_of_day_tenths_counter.sv
// Top level of the time-of-day counter kept in tenths of a second.
//
// The counter holds the time of day as tenths of a second, 0 to 863999, and wraps
// modulo one day. Each request on the s_ channel carries a mode (tick, add amount,
// subtract amount, set to amount, clear; other codes leave the count alone) and a
// 20-bit amount that is reduced modulo one day before use. Every request yields
// exactly one result on the m_ channel: the new count and its hours, minutes,
// seconds and tenths digit.
//
// A request passes through a request register, the day-count update, and the
// breakdown into result registers. The day-count update is combinational, so
// throughput is one request per cycle while m_ready keeps the stages moving.
// Each of the three stages holds its item when the next one is full, so s_ready
// stays high while bubbles remain and drops only when all stages are occupied and
// m_ready is low; nothing is lost or repeated under any stall pattern.
// Synchronous active-low reset clears the count to zero and empties all stages.
module time_of_day_tenths_counter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [19:0] s_amount,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [19:0] m_count,
    output logic [4:0]  m_hours,
    output logic [5:0]  m_minutes,
    output logic [5:0]  m_seconds,
    output logic [3:0]  m_tenths_digit
);

    tod_pkg::tod_count_t cnt;
    logic                cnt_ready;

    tod_update u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_amount  (s_amount),
        .cnt_o     (cnt),
        .cnt_ready (cnt_ready)
    );

    tod_split u_split (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cnt_i          (cnt),
        .cnt_ready      (cnt_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_count        (m_count),
        .m_hours        (m_hours),
        .m_minutes      (m_minutes),
        .m_seconds      (m_seconds),
        .m_tenths_digit (m_tenths_digit)
    );

endmodule

FILE: design/tod_update.sv
// Request register and day-count update stage of the time-of-day counter.
module tod_update (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [2:0]                 s_mode,
    input  logic [19:0]                s_amount,
    output tod_pkg::tod_count_t        cnt_o,
    input  logic                       cnt_ready
);

    logic                  req_valid_reg, req_valid_next;
    tod_pkg::mode_t        mode_reg;
    logic [19:0]           amt_reg;
    logic [19:0]           amt_wrapped;
    logic                  cnt_valid_reg, cnt_valid_next;
    logic [19:0]           day_count_reg, day_count_next;
    logic                  upd_ready;
    logic                  advance;
    logic                  accept;
    logic [20:0]           sum_w;
    logic [20:0]           diff_w;
    logic [19:0]           add_res;
    logic [19:0]           sub_res;
    logic [19:0]           tick_res;

    assign upd_ready = !cnt_valid_reg || cnt_ready;
    assign advance   = req_valid_reg && upd_ready;
    assign s_ready   = !req_valid_reg || upd_ready;
    assign accept    = s_valid && s_ready;

    // The amount is below twice a day, so one conditional subtract reduces it.
    assign amt_wrapped = (s_amount >= tod_pkg::DAY_TENTHS) ?
                         s_amount - tod_pkg::DAY_TENTHS : s_amount;

    assign sum_w    = {1'b0, day_count_reg} + {1'b0, amt_reg};
    assign add_res  = (sum_w >= {1'b0, tod_pkg::DAY_TENTHS}) ?
                      sum_w[19:0] - tod_pkg::DAY_TENTHS : sum_w[19:0];
    assign diff_w   = {1'b0, day_count_reg} - {1'b0, amt_reg};
    assign sub_res  = diff_w[20] ? diff_w[19:0] + tod_pkg::DAY_TENTHS : diff_w[19:0];
    assign tick_res = (day_count_reg == tod_pkg::DAY_TENTHS - 20'd1) ?
                      20'd0 : day_count_reg + 20'd1;

    always_comb begin
        day_count_next = day_count_reg;
        if (advance) begin
            case (mode_reg)
                tod_pkg::MODE_TICK:  day_count_next = tick_res;
                tod_pkg::MODE_ADD:   day_count_next = add_res;
                tod_pkg::MODE_SUB:   day_count_next = sub_res;
                tod_pkg::MODE_SET:   day_count_next = amt_reg;
                tod_pkg::MODE_CLEAR: day_count_next = 20'd0;
                default:             day_count_next = day_count_reg;
            endcase
        end
    end

    always_comb begin
        req_valid_next = req_valid_reg;
        if (accept) begin
            req_valid_next = 1'b1;
        end else if (advance) begin
            req_valid_next = 1'b0;
        end
        cnt_valid_next = cnt_valid_reg;
        if (advance) begin
            cnt_valid_next = 1'b1;
        end else if (cnt_ready) begin
            cnt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            cnt_valid_reg <= 1'b0;
            day_count_reg <= 20'd0;
        end else begin
            req_valid_reg <= req_valid_next;
            cnt_valid_reg <= cnt_valid_next;
            day_count_reg <= day_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= tod_pkg::mode_t'(s_mode);
            amt_reg  <= amt_wrapped;
        end
    end

    // The state register doubles as the payload of the hand-off stage.
    assign cnt_o.valid = cnt_valid_reg;
    assign cnt_o.count = day_count_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        day_count_reg < tod_pkg::DAY_TENTHS)
        else $error("day count left the range of one day");

    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && mode_reg == tod_pkg::MODE_SET |=> day_count_reg == $past(amt_reg))
        else $error("set request did not load the reduced amount");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance && !cnt_valid_reg |=> $stable(day_count_reg))
        else $error("day count changed without an update");

endmodule

FILE: design/tod_split.sv
// Breakdown of the count into hours, minutes, seconds and tenths, with the result register.
module tod_split (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tod_pkg::tod_count_t        cnt_i,
    output logic                       cnt_ready,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [19:0]                m_count,
    output logic [4:0]                 m_hours,
    output logic [5:0]                 m_minutes,
    output logic [5:0]                 m_seconds,
    output logic [3:0]                 m_tenths_digit
);

    logic                        res_valid_reg, res_valid_next;
    logic [19:0]                 count_reg;
    logic [4:0]                  hours_reg;
    logic [5:0]                  minutes_reg;
    logic [5:0]                  seconds_reg;
    logic [3:0]                  tenths_reg;
    logic [39:0]                 prod10;
    logic [39:0]                 prod600;
    logic [39:0]                 prod36k;
    logic [tod_pkg::SECS_W-1:0]  total_secs;
    logic [tod_pkg::MINS_W-1:0]  total_mins;
    logic [tod_pkg::HOURS_W-1:0] hours_q;
    logic [19:0]                 tenths_w;
    logic [tod_pkg::SECS_W-1:0]  secs_w;
    logic [tod_pkg::MINS_W-1:0]  mins_w;
    logic                        load;

    assign cnt_ready = !res_valid_reg || m_ready;
    assign load      = cnt_i.valid && cnt_ready;

    // Three independent reciprocal multiplies; the remainders only need constant multiples.
    assign prod10  = 40'(cnt_i.count) * 40'(tod_pkg::DIV10_MULT);
    assign prod600 = 40'(cnt_i.count) * 40'(tod_pkg::DIV600_MULT);
    assign prod36k = 40'(cnt_i.count) * 40'(tod_pkg::DIV36K_MULT);

    assign total_secs = prod10[tod_pkg::DIV10_SHIFT +: tod_pkg::SECS_W];
    assign total_mins = prod600[tod_pkg::DIV600_SHIFT +: tod_pkg::MINS_W];
    assign hours_q    = prod36k[tod_pkg::DIV36K_SHIFT +: tod_pkg::HOURS_W];

    assign tenths_w = cnt_i.count - 20'(total_secs) * 20'd10;
    assign secs_w   = total_secs - tod_pkg::SECS_W'(total_mins) * tod_pkg::SECS_W'(60);
    assign mins_w   = total_mins - tod_pkg::MINS_W'(hours_q) * tod_pkg::MINS_W'(60);

    always_comb begin
        res_valid_next = res_valid_reg;
        if (load) begin
            res_valid_next = 1'b1;
        end else if (m_ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            count_reg   <= cnt_i.count;
            hours_reg   <= hours_q;
            minutes_reg <= mins_w[5:0];
            seconds_reg <= secs_w[5:0];
            tenths_reg  <= tenths_w[3:0];
        end
    end

    assign m_valid        = res_valid_reg;
    assign m_count        = count_reg;
    assign m_hours        = hours_reg;
    assign m_minutes      = minutes_reg;
    assign m_seconds      = seconds_reg;
    assign m_tenths_digit = tenths_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> 24'(hours_reg) * 24'd36000 + 24'(minutes_reg) * 24'd600
                          + 24'(seconds_reg) * 24'd10 + 24'(tenths_reg) == 24'(count_reg))
        else $error("time fields do not add up to the count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid_reg |-> hours_reg < 5'd24 && minutes_reg < 6'd60
                          && seconds_reg < 6'd60 && tenths_reg < 4'd10)
        else $error("time field out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> res_valid_reg && count_reg == $past(cnt_i.count))
        else $error("result register missed a count");

endmodule
